>>> rtl/pic_pkg.sv
// Shared types, codes and helpers for the priority interrupt controller.
// No dependencies; every other file of the block imports this package.
package pic_pkg;

  // Lines served by the controller; the stored registers stay eight bits wide
  localparam int unsigned NUM_LINES = 8;
  localparam int unsigned REG_W     = 8;
  localparam int unsigned IRQ_W     = 4;
  localparam int unsigned LINE_W    = 3;

  localparam logic [REG_W-1:0] MASK_RESET = '1;

  typedef enum logic [2:0] {
    KIND_RAISE  = 3'd0,
    KIND_LOWER  = 3'd1,
    KIND_MASK   = 3'd2,
    KIND_UNMASK = 3'd3,
    KIND_ACK    = 3'd4,
    KIND_EOI    = 3'd5,
    KIND_QUERY  = 3'd6,
    KIND_SPARE  = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [IRQ_W-1:0]  irq;
  } event_t;

  typedef struct packed {
    logic [REG_W-1:0] request;
    logic [REG_W-1:0] service;
    logic [REG_W-1:0] mask;
  } regs_t;

  typedef struct packed {
    logic              pending_valid;
    logic [LINE_W-1:0] pending_line;
    logic [7:0]        pending_vector;
    logic [REG_W-1:0]  request_bits;
    logic [REG_W-1:0]  service_bits;
    logic [REG_W-1:0]  mask_bits;
    logic              line_masked;
    logic              service_valid;
    logic [LINE_W-1:0] service_level;
  } result_t;

  typedef struct packed {
    logic              found;
    logic [LINE_W-1:0] idx;
  } pick_t;

  // Lowest set bit wins; idx is zero when nothing is set
  function automatic pick_t lowest_set(input logic [REG_W-1:0] v);
    pick_t p;
    p.found = 1'b0;
    p.idx   = '0;
    for (int i = REG_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        p.found = 1'b1;
        p.idx   = LINE_W'(i);
      end
    end
    return p;
  endfunction

  // One-hot select of a line; zero for a line outside the served range
  function automatic logic [REG_W-1:0] line_bit(input logic [IRQ_W-1:0] irq);
    logic [REG_W-1:0] b;
    b = '0;
    if (irq < IRQ_W'(NUM_LINES)) begin
      b = REG_W'(1) << irq[LINE_W-1:0];
    end
    return b;
  endfunction

endpackage

>>> rtl/pic_in_if.sv
// Event channel of the priority interrupt controller: valid/ready plus word.
// Depends on pic_pkg for field widths.
interface pic_in_if import pic_pkg::*;;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic [IRQ_W-1:0]  irq;

  modport source (output valid, output kind, output irq, input ready);
  modport sink   (input valid, input kind, input irq, output ready);
endinterface

>>> rtl/pic_out_if.sv
// Result channel of the priority interrupt controller: valid/ready plus word.
// Depends on pic_pkg for field widths.
interface pic_out_if import pic_pkg::*;;
  logic              valid;
  logic              ready;
  logic              pending_valid;
  logic [LINE_W-1:0] pending_line;
  logic [7:0]        pending_vector;
  logic [REG_W-1:0]  request_bits;
  logic [REG_W-1:0]  service_bits;
  logic [REG_W-1:0]  mask_bits;
  logic              line_masked;
  logic              service_valid;
  logic [LINE_W-1:0] service_level;

  modport source (
    output valid, output pending_valid, output pending_line, output pending_vector,
    output request_bits, output service_bits, output mask_bits, output line_masked,
    output service_valid, output service_level, input ready
  );
  modport sink (
    input valid, input pending_valid, input pending_line, input pending_vector,
    input request_bits, input service_bits, input mask_bits, input line_masked,
    input service_valid, input service_level, output ready
  );
endinterface

>>> rtl/pic_state.sv
// Request, in-service and mask registers and their per-event update.
// Depends on pic_pkg.
module pic_state import pic_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   apply,
  input  event_t ev,
  output regs_t  regs_nxt
);

  regs_t            regs_r;
  logic [REG_W-1:0] sel;

  // Apply the event to the current registers
  always_comb begin
    sel      = line_bit(ev.irq);
    regs_nxt = regs_r;
    case (ev.kind)
      KIND_RAISE:  regs_nxt.request = regs_r.request | sel;
      KIND_LOWER:  regs_nxt.request = regs_r.request & ~sel;
      KIND_MASK:   regs_nxt.mask    = regs_r.mask | sel;
      KIND_UNMASK: regs_nxt.mask    = regs_r.mask & ~sel;
      KIND_ACK: begin
        regs_nxt.request = regs_r.request & ~sel;
        regs_nxt.service = regs_r.service | sel;
      end
      KIND_EOI:    regs_nxt.service = regs_r.service & ~sel;
      default:     regs_nxt = regs_r;
    endcase
  end

  // Commit when the word moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.request <= '0;
      regs_r.service <= '0;
      regs_r.mask    <= MASK_RESET;
    end else if (apply) begin
      regs_r <= regs_nxt;
    end
  end

endmodule

>>> rtl/pic_resolve.sv
// Priority resolution: service level, pending line, vector and line status.
// Depends on pic_pkg; purely combinational.
module pic_resolve import pic_pkg::*; (
  input  regs_t            regs,
  input  logic [IRQ_W-1:0] irq,
  input  logic [7:0]       base_vec,
  output result_t          res
);

  pick_t            svc;
  pick_t            pend;
  logic [REG_W-1:0] above;
  logic [REG_W-1:0] cand;
  logic [REG_W-1:0] sel;

  always_comb begin
    // Find the level currently in service
    svc   = lowest_set(regs.service);
    // Only lines of higher priority than that level may interrupt
    above = svc.found ? REG_W'((9'd1 << svc.idx) - 9'd1) : '1;
    cand  = regs.request & ~regs.mask & above;
    pend  = lowest_set(cand);
    sel   = line_bit(irq);

    res.pending_valid  = pend.found;
    res.pending_line   = pend.idx;
    res.pending_vector = pend.found ? 8'(base_vec + 8'(pend.idx)) : 8'd0;
    res.request_bits   = regs.request;
    res.service_bits   = regs.service;
    res.mask_bits      = regs.mask;
    res.line_masked    = (sel == '0) || ((regs.mask & sel) != '0);
    res.service_valid  = svc.found;
    res.service_level  = svc.idx;
  end

endmodule

>>> rtl/priority_interrupt_controller.sv
// Eight-line fully nested priority interrupt controller.
//
// Event words arrive on in_ch (kind, irq) with a valid/ready handshake; each
// accepted word yields exactly one result word on out_ch holding the pending
// line and vector, the three registers after the event, and the service level.
// cfg_we/cfg_wdata write the vector base; write it only while no word is in
// flight.
// Path: an accepted word waits in the input register, moves into the result register
// once that register is free, and shows on out_ch from then on until the receiver
// takes it.
// Throughput: one word per cycle while out_ch does not stall; the event is applied
// and resolved combinationally between the registers.
// Reset (rst_n low, synchronous): request and in-service clear, every line is
// masked, the vector base returns to zero and both channel stages empty.
// When the receiver stalls, the result word holds, the input register still
// fills, and in_ch.ready drops only once both stages are occupied.
// Depends on pic_pkg, pic_in_if, pic_out_if, pic_state and pic_resolve.
module priority_interrupt_controller import pic_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pic_in_if.sink      in_ch,
  pic_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  logic       s1_valid_r;
  event_t     s1_ev_r;
  logic       out_valid_r;
  result_t    result_r;
  logic [7:0] base_vec_r;

  logic       out_free;
  logic       s2_adv;
  regs_t      regs_nxt;
  result_t    result_nxt;

  // Handshake: stage two moves when the result register is free or drains
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s2_adv      = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || s2_adv;

  // Hold the configured vector base
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_vec_r <= '0;
    end else if (cfg_we) begin
      base_vec_r <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_ev_r.kind <= kind_t'(in_ch.kind);
      s1_ev_r.irq  <= in_ch.irq;
    end
  end

  pic_state u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .apply    (s2_adv),
    .ev       (s1_ev_r),
    .regs_nxt (regs_nxt)
  );

  pic_resolve u_resolve (
    .regs     (regs_nxt),
    .irq      (s1_ev_r.irq),
    .base_vec (base_vec_r),
    .res      (result_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.pending_valid  = result_r.pending_valid;
  assign out_ch.pending_line   = result_r.pending_line;
  assign out_ch.pending_vector = result_r.pending_vector;
  assign out_ch.request_bits   = result_r.request_bits;
  assign out_ch.service_bits   = result_r.service_bits;
  assign out_ch.mask_bits      = result_r.mask_bits;
  assign out_ch.line_masked    = result_r.line_masked;
  assign out_ch.service_valid  = result_r.service_valid;
  assign out_ch.service_level  = result_r.service_level;

`ifndef NO_ASSERTIONS
  // A reported pending line is requested and unmasked
  a_pend_unmasked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && result_r.pending_valid |->
      result_r.request_bits[result_r.pending_line] &&
      !result_r.mask_bits[result_r.pending_line])
    else $error("pending line not requested or masked");

  // A pending line always outranks the level in service
  a_pend_nested: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && result_r.pending_valid && result_r.service_valid |->
      result_r.pending_line < result_r.service_level)
    else $error("pending line does not outrank service level");

  // Service flag agrees with the in-service register
  a_svc_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> result_r.service_valid == (result_r.service_bits != '0))
    else $error("service_valid disagrees with service bits");

  // A word waiting in the input register moves on as soon as the output frees
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_free |=> out_valid_r)
    else $error("input stage did not advance");
`endif

endmodule

>>> verif/priority_interrupt_controller_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for priority_interrupt_controller: directed event table, then
// random event phases under several vector bases. Depends on pic_pkg, pic_in_if, pic_out_if.
module priority_interrupt_controller_tb;
  import pic_pkg::*;

  localparam int unsigned DIRECTED_ROWS = 25;
  localparam int unsigned PHASE_WORDS   = 125;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned LONG_HOLD     = 120;
  localparam int unsigned PRINT_LIMIT   = 200;

  // One row of the directed event table; want is used only where typed is set
  typedef struct {
    kind_t       kind;
    logic [3:0]  irq;
    bit          typed;
    result_t     want;
  } event_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  pic_in_if  in_if ();
  pic_out_if out_if ();

  priority_interrupt_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the controller registers and vector base
  logic [7:0] shadow_request;
  logic [7:0] shadow_service;
  logic [7:0] shadow_mask;
  logic [7:0] shadow_base;

  result_t     status_q [$];
  int unsigned mismatch_count;
  int unsigned words_checked;
  bit          steady_flow;
  int unsigned hold_off_cycles;

  // Directed events: reset state, spare kind, out-of-range lines, nesting and idle lines
  event_row_t event_table [DIRECTED_ROWS] = '{
    '{KIND_QUERY,  4'd0,  1'b1, '{1'b0, 3'd0, 8'd0, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b0, 3'd0}},
    '{KIND_SPARE,  4'd15, 1'b1, '{1'b0, 3'd0, 8'd0, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b0, 3'd0}},
    '{KIND_RAISE,  4'd15, 1'b1, '{1'b0, 3'd0, 8'd0, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b0, 3'd0}},
    '{KIND_RAISE,  4'd0,  1'b1, '{1'b0, 3'd0, 8'd0, 8'h01, 8'h00, 8'hFF, 1'b1, 1'b0, 3'd0}},
    '{KIND_UNMASK, 4'd0,  1'b1, '{1'b1, 3'd0, 8'd0, 8'h01, 8'h00, 8'hFE, 1'b0, 1'b0, 3'd0}},
    '{KIND_RAISE,  4'd7,  1'b0, '0},
    '{KIND_UNMASK, 4'd7,  1'b0, '0},
    '{KIND_ACK,    4'd0,  1'b0, '0},
    '{KIND_QUERY,  4'd7,  1'b0, '0},
    '{KIND_ACK,    4'd3,  1'b0, '0},
    '{KIND_EOI,    4'd0,  1'b0, '0},
    '{KIND_RAISE,  4'd1,  1'b0, '0},
    '{KIND_UNMASK, 4'd1,  1'b0, '0},
    '{KIND_EOI,    4'd6,  1'b0, '0},
    '{KIND_EOI,    4'd3,  1'b0, '0},
    '{KIND_LOWER,  4'd1,  1'b0, '0},
    '{KIND_LOWER,  4'd12, 1'b0, '0},
    '{KIND_MASK,   4'd7,  1'b0, '0},
    '{KIND_MASK,   4'd8,  1'b0, '0},
    '{KIND_UNMASK, 4'd15, 1'b0, '0},
    '{KIND_ACK,    4'd9,  1'b0, '0},
    '{KIND_EOI,    4'd14, 1'b0, '0},
    '{KIND_LOWER,  4'd7,  1'b0, '0},
    '{KIND_MASK,   4'd0,  1'b0, '0},
    '{KIND_QUERY,  4'd15, 1'b0, '0}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one event to the shadow registers and resolve the status word
  function automatic result_t resolve_event(input kind_t kind, input logic [3:0] irq);
    logic [7:0] sel;
    logic [7:0] cand;
    logic       in_range;
    int         level;
    result_t    r;
    in_range = irq < 4'd8;
    sel = in_range ? (8'd1 << irq[2:0]) : 8'h00;
    if (in_range) begin
      case (kind)
        KIND_RAISE:  shadow_request = shadow_request | sel;
        KIND_LOWER:  shadow_request = shadow_request & ~sel;
        KIND_MASK:   shadow_mask = shadow_mask | sel;
        KIND_UNMASK: shadow_mask = shadow_mask & ~sel;
        KIND_ACK: begin
          shadow_request = shadow_request & ~sel;
          shadow_service = shadow_service | sel;
        end
        KIND_EOI:    shadow_service = shadow_service & ~sel;
        default: ;
      endcase
    end
    r = '0;
    r.request_bits  = shadow_request;
    r.service_bits  = shadow_service;
    r.mask_bits     = shadow_mask;
    r.line_masked   = !in_range || ((shadow_mask & sel) != 8'h00);
    r.service_valid = shadow_service != 8'h00;
    level = 0;
    for (int i = 7; i >= 0; i--) begin
      if (shadow_service[i]) level = i;
    end
    r.service_level = 3'(level);
    // Only lines above the current service level may interrupt
    cand = shadow_request & ~shadow_mask;
    if (r.service_valid) cand = cand & ((8'd1 << level) - 8'd1);
    for (int i = 7; i >= 0; i--) begin
      if (cand[i]) begin
        r.pending_valid = 1'b1;
        r.pending_line  = 3'(i);
      end
    end
    if (r.pending_valid) r.pending_vector = shadow_base + 8'(r.pending_line);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("word %0d: %s", words_checked, msg);
  endtask

  // Compare one accepted status word against the oldest expectation
  task automatic check_status(input result_t got);
    result_t want;
    if (status_q.size() == 0) begin
      report_mismatch("status word with nothing expected");
      return;
    end
    want = status_q.pop_front();
    if (got.pending_valid !== want.pending_valid)
      report_mismatch($sformatf("pending_valid %0h want %0h", got.pending_valid,
                                want.pending_valid));
    if (got.pending_line !== want.pending_line)
      report_mismatch($sformatf("pending_line %0h want %0h", got.pending_line,
                                want.pending_line));
    if (got.pending_vector !== want.pending_vector)
      report_mismatch($sformatf("pending_vector %0h want %0h", got.pending_vector,
                                want.pending_vector));
    if (got.request_bits !== want.request_bits)
      report_mismatch($sformatf("request_bits %0h want %0h", got.request_bits,
                                want.request_bits));
    if (got.service_bits !== want.service_bits)
      report_mismatch($sformatf("service_bits %0h want %0h", got.service_bits,
                                want.service_bits));
    if (got.mask_bits !== want.mask_bits)
      report_mismatch($sformatf("mask_bits %0h want %0h", got.mask_bits, want.mask_bits));
    if (got.line_masked !== want.line_masked)
      report_mismatch($sformatf("line_masked %0h want %0h", got.line_masked,
                                want.line_masked));
    if (got.service_valid !== want.service_valid)
      report_mismatch($sformatf("service_valid %0h want %0h", got.service_valid,
                                want.service_valid));
    if (got.service_level !== want.service_level)
      report_mismatch($sformatf("service_level %0h want %0h", got.service_level,
                                want.service_level));
    words_checked++;
  endtask

  // Offer one event word after a random gap (none in steady flow); queue its status once accepted
  task automatic send_event(input kind_t kind, input logic [3:0] irq, input bit typed,
                            input result_t want);
    int unsigned gap;
    result_t predicted;
    gap = steady_flow ? 0 : $urandom_range(13, 0);
    repeat (gap) begin
      @(negedge clk);
      in_if.valid = 1'b0;
    end
    @(negedge clk);
    in_if.valid = 1'b1;
    in_if.kind  = kind;
    in_if.irq   = irq;
    do @(posedge clk); while (!in_if.ready);
    predicted = resolve_event(kind, irq);
    status_q.push_back(typed ? want : predicted);
  endtask

  // Stop offering, let every outstanding word drain, then write the vector base
  task automatic write_base(input logic [7:0] base);
    @(negedge clk);
    in_if.valid = 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we      = 1'b1;
    cfg_wdata   = base;
    @(negedge clk);
    cfg_we      = 1'b0;
    shadow_base = base;
  endtask

  // Random events, mostly on served lines, a few out of range
  task automatic random_events(input int unsigned count);
    kind_t      kind;
    logic [3:0] irq;
    for (int unsigned n = 0; n < count; n++) begin
      kind = kind_t'(3'($urandom_range(7, 0)));
      if ($urandom_range(99, 0) < 85) irq = 4'($urandom_range(7, 0));
      else irq = 4'($urandom_range(15, 8));
      send_event(kind, irq, 1'b0, '0);
    end
  endtask

  // Status receiver: random stalls (none in steady flow), plus a long hold-off when requested
  initial begin
    int unsigned stall;
    result_t got;
    out_if.ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(13, 0);
      if (hold_off_cycles != 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end
      repeat (stall) begin
        @(negedge clk);
        out_if.ready = 1'b0;
      end
      @(negedge clk);
      out_if.ready = 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      got.pending_valid  = out_if.pending_valid;
      got.pending_line   = out_if.pending_line;
      got.pending_vector = out_if.pending_vector;
      got.request_bits   = out_if.request_bits;
      got.service_bits   = out_if.service_bits;
      got.mask_bits      = out_if.mask_bits;
      got.line_masked    = out_if.line_masked;
      got.service_valid  = out_if.service_valid;
      got.service_level  = out_if.service_level;
      check_status(got);
    end
  end

  // Stimulus and end of run
  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 8'h00;
    in_if.valid     = 1'b0;
    in_if.kind      = KIND_QUERY;
    in_if.irq       = 4'd0;
    shadow_request  = 8'h00;
    shadow_service  = 8'h00;
    shadow_mask     = 8'hFF;
    shadow_base     = 8'h00;
    mismatch_count  = 0;
    words_checked   = 0;
    steady_flow     = 1'b0;
    hold_off_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (event_table[i])
      send_event(event_table[i].kind, event_table[i].irq, event_table[i].typed,
                 event_table[i].want);

    // Random phases at the base extremes and at arbitrary bases
    write_base(8'hFF);
    random_events(PHASE_WORDS);
    write_base(8'h00);
    steady_flow = 1'b1;
    random_events(PHASE_WORDS);
    steady_flow = 1'b0;
    write_base(8'($urandom_range(255, 0)));
    random_events(PHASE_WORDS);

    // Back-pressure: hold the receiver off while words keep coming
    write_base(8'($urandom_range(255, 0)));
    steady_flow     = 1'b1;
    hold_off_cycles = LONG_HOLD;
    random_events(30);
    steady_flow = 1'b0;

    write_base(8'($urandom_range(255, 0)));
    random_events(PHASE_WORDS);

    @(negedge clk);
    in_if.valid = 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (status_q.size() != 0) report_mismatch("status words never arrived");
    if (mismatch_count == 0) begin
      $display("priority_interrupt_controller_tb OK");
    end else begin
      $display("priority_interrupt_controller_tb NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("priority_interrupt_controller_tb NOT OK");
    $finish;
  end

endmodule

>>> sim.f
rtl/pic_pkg.sv
rtl/pic_in_if.sv
rtl/pic_out_if.sv
rtl/pic_state.sv
rtl/pic_resolve.sv
rtl/priority_interrupt_controller.sv
verif/priority_interrupt_controller_tb.sv
